/* design/assert_macros.svh */
// assertion helpers included by the receiver design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold on every clock edge out of reset
`define AST_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AST_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define AST_HOLDS(label, cond, msg)
`define AST_NEXT(label, ante, cons, msg)

`endif

`endif

/* design/car_pkg.sv */
package car_pkg;

	// sequence space and derived widths
	localparam int ADDR_W    = 12;
	localparam int PTR_W     = ADDR_W + 1;
	localparam int SEQ_SPACE = 1 << ADDR_W;

	// arriving segment word
	typedef struct packed {
		logic [ADDR_W-1:0] segment_number;
		logic              segment_lost;
	} seg_word_t;

	// acknowledgement word
	typedef struct packed {
		logic [ADDR_W-1:0] echo_number;
		logic              loss_reported;
		logic [PTR_W-1:0]  ack_number;
	} ack_word_t;

	// control states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_DONE
	} state_t;

endpackage

/* design/cumulative_ack_receiver.sv */
// channel | direction | word type  | handshake
// seg     | in        | seg_word_t | seg_valid / seg_ready
// ack     | out       | ack_word_t | ack_valid / ack_ready
//
// a lost segment is answered from the idle state; a received one is marked and walks the
// pointer over each marked bit, one memory read a cycle, until a clear bit or the end
// after reset all 4096 bitmap entries are cleared, one entry a cycle;
// seg_ready stays low during that pass
// a waiting ack is held in an output register; the block stalls in a done state
// only when a new ack is ready and the register is still occupied
`include "assert_macros.svh"

module cumulative_ack_receiver (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 seg_valid,
	output logic                 seg_ready,
	input  car_pkg::seg_word_t   seg_data,
	output logic                 ack_valid,
	input  logic                 ack_ready,
	output car_pkg::ack_word_t   ack_data
);
	import car_pkg::*;

	state_t            state_q, state_d;
	logic [PTR_W-1:0]  ptr_q, ptr_d;
	logic [ADDR_W-1:0] clr_q, clr_d;
	logic [ADDR_W-1:0] seg_q, seg_d;
	logic              lost_q, lost_d;
	logic              fwd_q, fwd_d;
	logic              ack_valid_q;
	ack_word_t         ack_data_q;

	logic              map_mem [SEQ_SPACE];
	logic              rd_data_q;
	logic [ADDR_W-1:0] rd_addr;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic              mem_wdata;

	logic              finish;
	logic              ack_load;
	logic              out_free;
	logic              bit_set;

	assign out_free = !ack_valid_q || ack_ready;
	assign bit_set  = rd_data_q || fwd_q;

	// bitmap memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= map_mem[rd_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ptr_q       <= '0;
			clr_q       <= '0;
			fwd_q       <= 1'b0;
			ack_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			clr_q   <= clr_d;
			fwd_q   <= fwd_d;
			if (ack_load) begin
				ack_valid_q <= 1'b1;
			end else if (ack_ready) begin
				ack_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		seg_q  <= seg_d;
		lost_q <= lost_d;
		if (ack_load) begin
			ack_data_q.echo_number   <= seg_d;
			ack_data_q.loss_reported <= lost_d;
			ack_data_q.ack_number    <= ptr_d;
		end
	end

	// next state, memory access and pointer update
	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		clr_d     = clr_q;
		seg_d     = seg_q;
		lost_d    = lost_q;
		fwd_d     = fwd_q;
		seg_ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = 1'b0;
		rd_addr   = ptr_q[ADDR_W-1:0];
		finish    = 1'b0;
		ack_load  = 1'b0;

		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				clr_d  = clr_q + 1'b1;
				if (clr_q == ADDR_W'(SEQ_SPACE - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				seg_ready = 1'b1;
				if (seg_valid) begin
					seg_d  = seg_data.segment_number;
					lost_d = seg_data.segment_lost;
					if (seg_data.segment_lost) begin
						// loss pulls the pointer back
						if ({1'b0, seg_data.segment_number} < ptr_q) begin
							ptr_d = {1'b0, seg_data.segment_number};
						end
						finish = 1'b1;
					end else begin
						// mark the segment and, unless the pointer is at the end, start the walk at the pointer
						mem_we    = 1'b1;
						mem_waddr = seg_data.segment_number;
						mem_wdata = 1'b1;
						fwd_d     = !ptr_q[PTR_W-1] &&
							(seg_data.segment_number == ptr_q[ADDR_W-1:0]);
						if (ptr_q[PTR_W-1]) begin
							finish = 1'b1;
						end else begin
							state_d = ST_CHECK;
						end
					end
				end
			end
			ST_CHECK: begin
				// step past a set bit and read the following one
				fwd_d = 1'b0;
				if (bit_set) begin
					ptr_d   = ptr_q + 1'b1;
					rd_addr = ptr_d[ADDR_W-1:0];
					if (ptr_d[PTR_W-1]) begin
						finish = 1'b1;
					end
				end else begin
					finish = 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					ack_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// hand the ack to the output register
		if (finish) begin
			if (out_free) begin
				ack_load = 1'b1;
				state_d  = ST_IDLE;
			end else begin
				state_d = ST_DONE;
			end
		end
	end

	assign ack_valid = ack_valid_q;
	assign ack_data  = ack_data_q;

	// checks
	`AST_HOLDS(a_no_accept_in_clear, !(state_q == ST_CLEAR && seg_ready), "word accepted during clear")
	`AST_HOLDS(a_ack_in_range, !ack_valid || ack_data.ack_number <= PTR_W'(SEQ_SPACE), "ack beyond space")
	`AST_NEXT(a_walk_forward, state_q == ST_CHECK, ptr_q >= $past(ptr_q), "pointer moved back in walk")
	`AST_NEXT(a_loss_pulls, seg_valid && seg_ready && seg_data.segment_lost, ptr_q <= PTR_W'($past(seg_data.segment_number)), "loss left pointer high")
	`AST_NEXT(a_received_walks, seg_valid && seg_ready && !seg_data.segment_lost && !ptr_q[PTR_W-1], state_q == ST_CHECK, "received word skipped walk")

endmodule
